// ===== design/dmf_pkg.sv =====
// shared constants of the duplicate message filter
`default_nettype none

package dmf_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 8;
  localparam int unsigned TITLE_BYTES_DEFAULT = 8;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned KEY_IN_W = 64;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd120000;

endpackage : dmf_pkg

`default_nettype wire

// ===== design/duplicate_message_filter_core.sv =====
// duplicate message filter: timed history table in one synchronous memory
// a checked word walks the table and the walk stops at the first match; an exempt word
// or one without sequence number skips the walk and is neither checked nor recorded
// the single read port walks the table one entry per cycle, and no new word is accepted
// until the walk of the last one is over and its result is in the output register
// reset: entries freed through per-entry valid flops, next slot 0, timeout 120000 ms
`default_nettype none

module duplicate_message_filter_core import dmf_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = DEPTH_DEFAULT,
  parameter int unsigned TITLE_BYTES   = TITLE_BYTES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [TIME_W-1:0]   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [TIME_W-1:0]   in_now_ms,
  input  wire logic                in_seq_present,
  input  wire logic [SEQ_W-1:0]    in_seq_number,
  input  wire logic                in_title_present,
  input  wire logic [KEY_IN_W-1:0] in_title_key,
  input  wire logic                in_exempt,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_duplicate,
  output logic                     out_recorded
);

  localparam int unsigned KEY_W = TITLE_BYTES * 8;
  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              has_title;
    logic [KEY_W-1:0]  title;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // history memory
  entry_t             mem [HISTORY_DEPTH];
  entry_t             rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  entry_t             wr_data;

  state_t             state_r, state_nxt;
  logic [TIME_W-1:0]  timeout_r;
  logic [HISTORY_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]   next_slot_r, next_slot_nxt;
  logic [CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               res_dup_r, res_dup_nxt;
  logic               res_rec_r, res_rec_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_duplicate_r, out_duplicate_nxt;
  logic               out_recorded_r, out_recorded_nxt;

  // latched word
  logic [TIME_W-1:0]  now_r;
  logic [SEQ_W-1:0]   seq_r;
  logic               ht_r;
  logic [KEY_W-1:0]   key_r;

  logic               live;
  logic [TIME_W-1:0]  age;
  logic               expired;
  logic               hit;
  logic               accept;

  assign cfg_ready     = 1'b1;
  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_duplicate = out_duplicate_r;
  assign out_recorded  = out_recorded_r;

  assign live    = cmp_v_r && valid_r[cmp_idx_r];
  assign age     = now_r - rd_data_r.stamp;
  assign expired = live && (age > timeout_r);
  assign hit     = live && !expired && (rd_data_r.seq == seq_r) &&
                   (rd_data_r.has_title == ht_r) &&
                   (!ht_r || (rd_data_r.title == key_r));

  assign wr_data.seq       = seq_r;
  assign wr_data.has_title = ht_r;
  assign wr_data.title     = key_r;
  assign wr_data.stamp     = (now_r == '0) ? TIME_W'(1) : now_r;

  always_comb begin
    state_nxt         = state_r;
    valid_nxt         = valid_r;
    next_slot_nxt     = next_slot_r;
    issue_cnt_nxt     = issue_cnt_r;
    cmp_v_nxt         = 1'b0;
    cmp_idx_nxt       = cmp_idx_r;
    res_dup_nxt       = res_dup_r;
    res_rec_nxt       = res_rec_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_duplicate_nxt = out_duplicate_r;
    out_recorded_nxt  = out_recorded_r;
    rd_en             = 1'b0;
    rd_addr           = issue_cnt_r[IDX_W-1:0];
    wr_en             = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_dup_nxt   = 1'b0;
          res_rec_nxt   = 1'b0;
          issue_cnt_nxt = '0;
          if (in_exempt || !in_seq_present) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (expired) begin
          valid_nxt[cmp_idx_r] = 1'b0;
        end
        if (hit) begin
          res_dup_nxt = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (cmp_v_r && (cmp_idx_r == LAST_IDX)) begin
          wr_en                  = 1'b1;
          valid_nxt[next_slot_r] = 1'b1;
          next_slot_nxt = (next_slot_r == LAST_IDX) ? '0 : next_slot_r + 1'b1;
          res_rec_nxt   = 1'b1;
          state_nxt     = ST_FINISH;
        end else if (issue_cnt_r < CNT_END) begin
          rd_en         = 1'b1;
          cmp_v_nxt     = 1'b1;
          cmp_idx_nxt   = issue_cnt_r[IDX_W-1:0];
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_duplicate_nxt = res_dup_r;
          out_recorded_nxt  = res_rec_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timeout_r   <= TIMEOUT_RESET;
      valid_r     <= '0;
      next_slot_r <= '0;
      issue_cnt_r <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r       <= cmp_idx_nxt;
    res_dup_r       <= res_dup_nxt;
    res_rec_r       <= res_rec_nxt;
    out_duplicate_r <= out_duplicate_nxt;
    out_recorded_r  <= out_recorded_nxt;
    if (accept) begin
      now_r <= in_now_ms;
      seq_r <= in_seq_number;
      ht_r  <= in_title_present;
      key_r <= in_title_key[KEY_W-1:0] & {KEY_W{in_title_present}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[next_slot_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_duplicate_r && out_recorded_r))
    else $error("duplicate and recorded both set");

  a_hit_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && hit) |=> (state_r == ST_FINISH && res_dup_r && !res_rec_r))
    else $error("match not reported as duplicate");

  a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmp_v_r)
    else $error("compare pending while idle");

  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (valid_r != '0))
    else $error("recorded entry not live");
`endif

endmodule : duplicate_message_filter_core

`default_nettype wire
